// File: sv/bssw_pkg.sv
// Shared constants and types, including the hash constants, for the strip walk core.
package bssw_pkg;

  localparam int YBits = 16;
  localparam int CfgIdxBits = 3;

  localparam logic [CfgIdxBits-1:0] CFG_STRIP_WIDTH   = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_BOUNDARY_MODE = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_RIGHT_LIMIT   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_LEFT_LIMIT    = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_UP_LIMIT      = 3'd4;

  localparam logic [63:0] MIX_M1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_M2   = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] GOLDEN   = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] Y_MULT   = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] RNG_SALT = 64'h5851F42D4C957F2D;
  localparam logic [63:0] KEY_SALT = 64'hA24BAED4963EE407;

  // Datapath operations issued by the controller
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD_SEED = 4'd1;  // a = seed ^ rng salt
  localparam logic [3:0] OP_LOAD_KEY  = 4'd2;  // a = seed ^ key salt
  localparam logic [3:0] OP_MIX_A     = 4'd3;  // partials of (a ^ a>>33) * M1 or M2 (three 32x32)
  localparam logic [3:0] OP_MIX_B     = 4'd4;  // finish multiply
  localparam logic [3:0] OP_GEN_STEP  = 4'd5;  // advance generator, move walker
  localparam logic [3:0] OP_SITE      = 4'd6;  // a = site + key
  localparam logic [3:0] OP_STORE_KEY = 4'd7;  // key = a, clear walker
  localparam logic [3:0] OP_SEED_WORD = 4'd8;  // k += golden, a = k
  localparam logic [3:0] OP_PUT_WORD  = 4'd9;  // word[idx] = a
  localparam logic [3:0] OP_LOAD_K    = 4'd10; // k = a
  localparam logic [3:0] OP_FIX_ZERO  = 4'd11;
  localparam logic [3:0] OP_SITE_MUL  = 4'd12; // first partial of site product

  typedef struct packed {
    logic [3:0] op;
    logic       sel_m2;   // mixer pass uses the second constant
    logic       last_xor; // final xor-shift of mix64
    logic [1:0] word_idx;
    logic       result_load;
  } bssw_cmd_t;

  typedef struct packed {
    logic seed_zero;
  } bssw_status_t;

endpackage

// File: sv/bssw_ctrl.sv
// Controller state machine sequencing start, step and hash operations.
module bssw_ctrl
  import bssw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_func,
  output logic         out_valid,
  input  logic         out_stall,
  output bssw_cmd_t    cmd,
  input  bssw_status_t status
);

  // Each mix64 is: pass M1 (A then B), pass M2 (A then B), final xor
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_KEY    = 5'd1;   // seed ^ key salt
  localparam logic [4:0] S_KM1A   = 5'd2;
  localparam logic [4:0] S_KM1B   = 5'd3;
  localparam logic [4:0] S_KM2A   = 5'd4;
  localparam logic [4:0] S_KM2B   = 5'd5;
  localparam logic [4:0] S_KST    = 5'd6;   // store key (with final xor)
  localparam logic [4:0] S_RNG    = 5'd7;   // seed ^ rng salt
  localparam logic [4:0] S_RM1A   = 5'd8;
  localparam logic [4:0] S_RM1B   = 5'd9;
  localparam logic [4:0] S_RM2A   = 5'd10;
  localparam logic [4:0] S_RM2B   = 5'd11;
  localparam logic [4:0] S_RK     = 5'd12;  // k = mix (with final xor)
  localparam logic [4:0] S_WADD   = 5'd13;  // k += golden
  localparam logic [4:0] S_WM1A   = 5'd14;
  localparam logic [4:0] S_WM1B   = 5'd15;
  localparam logic [4:0] S_WM2A   = 5'd16;
  localparam logic [4:0] S_WM2B   = 5'd17;
  localparam logic [4:0] S_WPUT   = 5'd18;
  localparam logic [4:0] S_FIX    = 5'd19;
  localparam logic [4:0] S_STEP   = 5'd20;
  localparam logic [4:0] S_SMUL   = 5'd21;
  localparam logic [4:0] S_SITE   = 5'd22;
  localparam logic [4:0] S_HM1A   = 5'd23;
  localparam logic [4:0] S_HM1B   = 5'd24;
  localparam logic [4:0] S_HM2A   = 5'd25;
  localparam logic [4:0] S_HM2B   = 5'd26;
  localparam logic [4:0] S_HOUT   = 5'd27;

  logic [4:0] state, state_next;
  logic [1:0] widx, widx_next;
  logic       out_valid_next;

  // The result register must be free before a new item enters
  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    state_next     = state;
    widx_next      = widx;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.word_idx   = widx;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          state_next = in_func ? S_STEP : S_KEY;
        end
      end
      S_KEY:  begin cmd.op = OP_LOAD_KEY; state_next = S_KM1A; end
      S_KM1A: begin cmd.op = OP_MIX_A; state_next = S_KM1B; end
      S_KM1B: begin cmd.op = OP_MIX_B; state_next = S_KM2A; end
      S_KM2A: begin cmd.op = OP_MIX_A; cmd.sel_m2 = 1'b1; state_next = S_KM2B; end
      S_KM2B: begin cmd.op = OP_MIX_B; cmd.sel_m2 = 1'b1; state_next = S_KST; end
      S_KST:  begin cmd.op = OP_STORE_KEY; cmd.last_xor = 1'b1; state_next = S_RNG; end
      S_RNG:  begin cmd.op = OP_LOAD_SEED; state_next = S_RM1A; end
      S_RM1A: begin cmd.op = OP_MIX_A; state_next = S_RM1B; end
      S_RM1B: begin cmd.op = OP_MIX_B; state_next = S_RM2A; end
      S_RM2A: begin cmd.op = OP_MIX_A; cmd.sel_m2 = 1'b1; state_next = S_RM2B; end
      S_RM2B: begin cmd.op = OP_MIX_B; cmd.sel_m2 = 1'b1; state_next = S_RK; end
      S_RK: begin
        cmd.op = OP_LOAD_K; cmd.last_xor = 1'b1;
        widx_next = 2'd0; state_next = S_WADD;
      end
      S_WADD: begin cmd.op = OP_SEED_WORD; state_next = S_WM1A; end
      S_WM1A: begin cmd.op = OP_MIX_A; state_next = S_WM1B; end
      S_WM1B: begin cmd.op = OP_MIX_B; state_next = S_WM2A; end
      S_WM2A: begin cmd.op = OP_MIX_A; cmd.sel_m2 = 1'b1; state_next = S_WM2B; end
      S_WM2B: begin cmd.op = OP_MIX_B; cmd.sel_m2 = 1'b1; state_next = S_WPUT; end
      S_WPUT: begin
        cmd.op = OP_PUT_WORD; cmd.last_xor = 1'b1;
        widx_next  = widx + 2'd1;
        state_next = (widx == 2'd3) ? S_FIX : S_WADD;
      end
      // Force word zero to one only when seeding left all words zero
      S_FIX: begin
        cmd.op = status.seed_zero ? OP_FIX_ZERO : OP_NONE;
        state_next = S_SMUL;
      end
      S_STEP: begin cmd.op = OP_GEN_STEP; state_next = S_SMUL; end
      S_SMUL: begin cmd.op = OP_SITE_MUL; state_next = S_SITE; end
      S_SITE: begin cmd.op = OP_SITE; state_next = S_HM1A; end
      S_HM1A: begin cmd.op = OP_MIX_A; state_next = S_HM1B; end
      S_HM1B: begin cmd.op = OP_MIX_B; state_next = S_HM2A; end
      S_HM2A: begin cmd.op = OP_MIX_A; cmd.sel_m2 = 1'b1; state_next = S_HM2B; end
      S_HM2B: begin cmd.op = OP_MIX_B; cmd.sel_m2 = 1'b1; state_next = S_HOUT; end
      S_HOUT: begin
        cmd.last_xor = 1'b1; cmd.result_load = 1'b1;
        out_valid_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      widx      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      widx      <= widx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: sv/bssw_dp.sv
// Datapath: generator words, walker state, shared mixer and result registers.
module bssw_dp
  import bssw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_idx,
  input  logic [53:0]        cfg_data,
  input  logic               in_accept,
  input  logic [63:0]        seed_in,
  input  bssw_cmd_t          cmd,
  output bssw_status_t       status,
  output logic signed [63:0] x_out,
  output logic [YBits-1:0]   y_out,
  output logic [63:0]        steps_out,
  output logic [63:0]        hash_out
);

  logic [15:0] strip_width;
  logic        boundary_mode;
  logic [53:0] right_limit, left_limit, up_limit;

  logic [63:0] gw [4];
  logic [63:0] walker_x, steps_taken, disorder_key;
  logic [YBits-1:0] walker_y;
  logic [63:0] seed, acc, kreg, plo;
  logic [31:0] phi, pmid, yhi;
  logic [47:0] ylo;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strip_width   <= 16'd5;
      boundary_mode <= 1'b0;
      right_limit   <= 54'd2251799813685248;
      left_limit    <= 54'd4503599627370496;
      up_limit      <= 54'd6755399441055744;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_STRIP_WIDTH:   strip_width   <= cfg_data[15:0];
        CFG_BOUNDARY_MODE: boundary_mode <= cfg_data[0];
        CFG_RIGHT_LIMIT:   right_limit   <= cfg_data;
        CFG_LEFT_LIMIT:    left_limit    <= cfg_data;
        CFG_UP_LIMIT:      up_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Mixer: low 64 bits of a 64x64 product from three 32x32 partials
  logic [63:0] mconst, xs, fin, ma, mb, p_ll;
  logic [31:0] p_hl, p_lh, py_h;
  logic [47:0] py_l;
  assign mconst = cmd.sel_m2 ? MIX_M2 : MIX_M1;
  assign xs     = acc ^ (acc >> 33);
  assign fin    = acc ^ (acc >> 33);

  // Site product x*golden reuses the partial multipliers
  assign ma   = (cmd.op == OP_SITE_MUL) ? walker_x : xs;
  assign mb   = (cmd.op == OP_SITE_MUL) ? GOLDEN : mconst;
  assign p_ll = {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
  assign p_hl = ma[63:32] * mb[31:0];
  assign p_lh = ma[31:0] * mb[63:32];

  // y*ymult partials: narrow y against each half of the constant
  assign py_l = 48'(walker_y) * 48'(Y_MULT[31:0]);
  assign py_h = 32'(walker_y) * Y_MULT[63:32];

  // Generator step
  logic [63:0] g0, g1, g2, g3, t17, sum03, draw;
  logic [52:0] u0;
  logic [53:0] u;
  always_comb begin
    sum03 = gw[0] + gw[3];
    draw  = {sum03[40:0], sum03[63:41]} + gw[0];
    t17   = gw[1] << 17;
    g2 = gw[2] ^ gw[0];
    g3 = gw[3] ^ gw[1];
    g1 = gw[1] ^ g2;
    g0 = gw[0] ^ g3;
    g2 = g2 ^ t17;
    g3 = {g3[18:0], g3[63:19]};
    u0 = draw[63:11];
    u  = {1'b0, u0} + 54'd1;
  end

  // Effective width and clamped y
  logic [YBits:0] w_eff, yc, yinc;
  always_comb begin
    w_eff = (strip_width == 16'd0) ? 17'd1 : {1'b0, strip_width};
    yc    = ({1'b0, walker_y} >= w_eff) ? w_eff - 17'd1 : {1'b0, walker_y};
    yinc  = yc + 17'd1;
  end

  logic [YBits-1:0] y_new;
  always_comb begin
    y_new = yc[YBits-1:0];
    if (u < right_limit || u < left_limit) begin
      y_new = yc[YBits-1:0];
    end else if (u < up_limit) begin
      if (!boundary_mode) y_new = (yinc == w_eff) ? '0 : yinc[YBits-1:0];
      else if (yinc < w_eff) y_new = yinc[YBits-1:0];
    end else begin
      if (!boundary_mode) y_new = (yc == '0) ? w_eff[YBits-1:0] - YBits'(1)
                                             : yc[YBits-1:0] - YBits'(1);
      else if (yc != '0) y_new = yc[YBits-1:0] - YBits'(1);
    end
  end

  assign status.seed_zero = ((gw[0] | gw[1] | gw[2] | gw[3]) == 64'd0);

  always_ff @(posedge clk) begin
    if (in_accept) seed <= seed_in;
    unique case (cmd.op)
      OP_LOAD_SEED: acc <= seed ^ RNG_SALT;
      OP_LOAD_KEY:  acc <= seed ^ KEY_SALT;
      OP_MIX_A: begin
        plo  <= p_ll;
        phi  <= p_hl;
        pmid <= p_lh;
      end
      OP_MIX_B:     acc <= plo + {phi + pmid, 32'd0};
      OP_SEED_WORD: begin
        kreg <= kreg + GOLDEN;
        acc  <= kreg + GOLDEN;
      end
      OP_SITE_MUL: begin
        plo  <= p_ll;
        phi  <= p_hl;
        pmid <= p_lh;
        ylo  <= py_l;
        yhi  <= py_h;
      end
      OP_SITE: acc <= plo + {phi + pmid, 32'd0} + {16'd0, ylo} + {yhi, 32'd0}
                      + disorder_key;
      default: ;
    endcase
    if (cmd.op == OP_LOAD_K) kreg <= fin;
    if (cmd.result_load) begin
      hash_out  <= fin;
      x_out     <= walker_x;
      y_out     <= walker_y;
      steps_out <= steps_taken;
    end
  end

  // Architectural walker and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      gw[0] <= 64'd1; gw[1] <= '0; gw[2] <= '0; gw[3] <= '0;
      walker_x <= '0; walker_y <= '0; steps_taken <= '0; disorder_key <= '0;
    end else begin
      unique case (cmd.op)
        OP_STORE_KEY: begin
          disorder_key <= fin;
          walker_x <= '0; walker_y <= '0; steps_taken <= '0;
        end
        OP_PUT_WORD: gw[cmd.word_idx] <= fin;
        OP_FIX_ZERO: gw[0] <= 64'd1;
        OP_GEN_STEP: begin
          gw[0] <= g0; gw[1] <= g1; gw[2] <= g2; gw[3] <= g3;
          if (u < right_limit) walker_x <= walker_x + 64'd1;
          else if (u < left_limit) walker_x <= walker_x - 64'd1;
          walker_y    <= y_new;
          steps_taken <= steps_taken + 64'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: sv/biased_strip_walk_step_core.sv
// Top level of the biased strip random walk core.
// Each item yields one result. A step item runs the generator update, the
// site product partials, the site sum, one mix64 over the shared 32x32
// partial multipliers and the final xor into the result register. A start
// item runs mix64 for the disorder key, for the generator seed and for each
// of the four generator words, the all-zero check, then the same site hash.
// The input stalls while an item is in work or its result waits, so a new
// item is taken only after the last result has been accepted.
module biased_strip_walk_step_core
  import bssw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [53:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [63:0]           seed_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [63:0]    x_position,
  output logic [YBits-1:0]      y_position,
  output logic [63:0]           step_count,
  output logic [63:0]           site_hash
);

  bssw_cmd_t    cmd;
  bssw_status_t status;

  bssw_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_func(func),
    .out_valid, .out_stall, .cmd, .status
  );

  bssw_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .in_accept(in_valid && !in_stall), .seed_in(seed_value),
    .cmd, .status,
    .x_out(x_position), .y_out(y_position),
    .steps_out(step_count), .hash_out(site_hash)
  );

endmodule

// File: sv/bssw_checker.sv
// Port-level checker for the strip walk core, bound to the top level.
module bssw_checker
  import bssw_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [YBits-1:0] y_position,
  input logic [63:0]      step_count
);

  // No input transfer while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");

  // Result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(step_count) && $stable(y_position))
    else $error("stalled result changed");

  // No result in the cycle after a transfer
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid) else $error("result too early");

endmodule

bind biased_strip_walk_step_core bssw_checker u_bssw_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .y_position, .step_count
);
